/* hw/rtl/kwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way sorted stream merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int ST_W        = 2;
	localparam int MAX_RESULTS = 16;

	typedef logic [ST_W-1:0] status_t;

	localparam status_t ST_MERGED = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_CLOSED = 2'd2;

	// classification of a queued push
	typedef struct packed {
		logic fin;
		logic in_range;
	} kwm_cls_t;

endpackage
`default_nettype wire

/* hw/rtl/kwm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_if
// Valid/ready channels for pushed values and merged results.
// ----------------------------------------------------------------------------
interface kwm_in_if #(
	parameter int LANE_W      = 2,
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [LANE_W-1:0]             lane;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          final_in_lane;

	modport source (output valid, lane, value, final_in_lane, input ready);
	modport sink   (input valid, lane, value, final_in_lane, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; #(
	parameter int LANE_W      = 2,
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] merged_value;
	logic [LANE_W-1:0]             source_lane;
	status_t                       status;
	logic                          merge_done;
	logic                          burst_end;

	modport source (output valid, merged_value, source_lane, status, merge_done, burst_end,
		input ready);
	modport sink   (input valid, merged_value, source_lane, status, merge_done, burst_end,
		output ready);
endinterface
`default_nettype wire

/* hw/rtl/kwm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_front
// Accepts pushes, flags out-of-range lanes and queues them two deep.
// ----------------------------------------------------------------------------
module kwm_front import kwm_pkg::*; #(
	parameter int LANES       = 4,
	parameter int VALUE_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	kwm_in_if.sink                       in_ch,
	output logic                         q_valid,
	output logic [$clog2(LANES)-1:0]     q_lane,
	output logic signed [VALUE_WIDTH-1:0] q_value,
	output kwm_cls_t                     q_cls,
	input  wire                          take
);
	localparam int LANE_W = $clog2(LANES);

	logic [LANE_W-1:0]             lane_q [2];
	logic signed [VALUE_WIDTH-1:0] val_q  [2];
	kwm_cls_t                      cls_q  [2];
	logic                          wr_ptr_q;
	logic                          rd_ptr_q;
	logic [1:0]                    cnt_q;
	logic                          push;
	kwm_cls_t                      cls_in;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;

	always_comb begin
		cls_in.fin      = in_ch.final_in_lane;
		cls_in.in_range = ({1'b0, in_ch.lane} < (LANE_W + 1)'(LANES));
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_lane  = lane_q[rd_ptr_q];
	assign q_value = val_q[rd_ptr_q];
	assign q_cls   = cls_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (take)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !take)
				cnt_q <= cnt_q + 2'd1;
			else if (take && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			lane_q[wr_ptr_q] <= in_ch.lane;
			val_q[wr_ptr_q]  <= in_ch.value;
			cls_q[wr_ptr_q]  <= cls_in;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/kwm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_back
// Lane buffers, push/drop handling and the minimum-selecting drain loop.
// ----------------------------------------------------------------------------
module kwm_back import kwm_pkg::*; #(
	parameter int LANES       = 4,
	parameter int LANE_DEPTH  = 4,
	parameter int VALUE_WIDTH = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire [LANES-1:0]               active,
	input  wire                           q_valid,
	input  wire [$clog2(LANES)-1:0]       q_lane,
	input  wire signed [VALUE_WIDTH-1:0]  q_value,
	input  kwm_cls_t                      q_cls,
	output logic                          take,
	kwm_out_if.source                     out_ch
);
	localparam int LANE_W = $clog2(LANES);
	localparam int FILL_W = $clog2(LANE_DEPTH + 1);
	localparam int IDX_W  = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EMIT = 1'b1;

	logic                          state_q;
	logic                          drop_q;
	status_t                       drop_st_q;
	logic [LANE_W-1:0]             drop_lane_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [FILL_W-1:0]             fill_q [LANES];
	logic [LANES-1:0]              closed_q;
	logic signed [VALUE_WIDTH-1:0] buf_q [LANES][LANE_DEPTH];

	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] out_val_q;
	logic [LANE_W-1:0]             out_lane_q;
	status_t                       out_st_q;
	logic                          out_done_q;
	logic                          out_end_q;

	logic [LANES-1:0]              ceff;
	logic [LANES-1:0]              ceff_s;
	logic [LANES-1:0]              closed_take;
	logic [LANES-1:0]              nonempty;
	logic [LANES-1:0]              rest;
	logic                          all_done;
	logic                          ready_all;
	logic                          any;
	logic                          found;
	logic [LANE_W-1:0]             best_lane;
	logic signed [VALUE_WIDTH-1:0] best_val;
	logic                          best_one;
	logic                          done_now;
	logic                          ready_after;
	logic                          can_pop;
	logic                          more_room;
	logic                          out_free;
	logic                          s_closed;
	logic                          s_full;
	logic                          push;
	logic                          emit_drop;
	logic                          emit_pop;
	logic                          end_none;
	logic                          drop_last;
	logic                          pop_last;

	always_comb begin
		for (int l = 0; l < LANES; l++)
			nonempty[l] = (fill_q[l] != '0);
		ceff      = closed_q | ~active;
		all_done  = (&ceff) && !(|nonempty);
		ready_all = &(nonempty | ceff);
		any       = |nonempty;

		found     = 1'b0;
		best_lane = '0;
		best_val  = '0;
		for (int l = 0; l < LANES; l++) begin
			if (nonempty[l] && (!found || (buf_q[l][0] < best_val))) begin
				found     = 1'b1;
				best_lane = LANE_W'(l);
				best_val  = buf_q[l][0];
			end
		end

		rest            = nonempty;
		rest[best_lane] = 1'b0;
		best_one        = (fill_q[best_lane] == FILL_W'(1));
		done_now        = (&ceff) && best_one && !(|rest);
		ready_after     = ready_all && (!best_one || ceff[best_lane]);
		can_pop         = ready_all && any && (cnt_q < CNT_W'(MAX_RESULTS));
		more_room       = (cnt_q < CNT_W'(MAX_RESULTS - 1));
		out_free        = !out_valid_q || out_ch.ready;

		ceff_s   = all_done ? ~active : ceff;
		s_closed = !q_cls.in_range || ceff_s[q_lane];
		s_full   = (fill_q[q_lane] == FILL_W'(LANE_DEPTH));

		take      = (state_q == S_IDLE) && q_valid;
		push      = take && !s_closed && !s_full;
		emit_drop = (state_q == S_EMIT) && out_free && drop_q;
		emit_pop  = (state_q == S_EMIT) && out_free && !drop_q && can_pop;
		end_none  = (state_q == S_EMIT) && out_free && !drop_q && !can_pop;
		drop_last = !(more_room && ready_all && any);
		pop_last  = !(more_room && !done_now && ready_after);

		// reopen first, then a final mark closes the pushed lane
		closed_take = all_done ? ~active : closed_q;
		if (push && q_cls.fin)
			closed_take[q_lane] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			drop_q      <= 1'b0;
			cnt_q       <= '0;
			closed_q    <= ~LANES'(4'hF);
			out_valid_q <= 1'b0;
			for (int l = 0; l < LANES; l++)
				fill_q[l] <= '0;
		end else begin
			if (take) begin
				state_q  <= S_EMIT;
				cnt_q    <= '0;
				drop_q   <= !push;
				closed_q <= closed_take;
				if (push)
					fill_q[q_lane] <= fill_q[q_lane] + FILL_W'(1);
			end
			if (emit_drop) begin
				drop_q <= 1'b0;
				cnt_q  <= cnt_q + CNT_W'(1);
				if (drop_last)
					state_q <= S_IDLE;
			end
			if (emit_pop) begin
				fill_q[best_lane] <= fill_q[best_lane] - FILL_W'(1);
				cnt_q             <= cnt_q + CNT_W'(1);
				if (done_now)
					closed_q <= ~active;
				if (pop_last)
					state_q <= S_IDLE;
			end
			if (end_none)
				state_q <= S_IDLE;
			if (emit_drop || emit_pop)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[q_lane][fill_q[q_lane][IDX_W-1:0]] <= q_value;
		if (take) begin
			drop_st_q   <= s_closed ? ST_CLOSED : ST_FULL;
			drop_lane_q <= q_lane;
		end
		if (emit_pop) begin
			for (int k = 0; k < LANE_DEPTH - 1; k++)
				buf_q[best_lane][k] <= buf_q[best_lane][k + 1];
		end
		if (emit_drop) begin
			out_val_q  <= '0;
			out_lane_q <= drop_lane_q;
			out_st_q   <= drop_st_q;
			out_done_q <= 1'b0;
			out_end_q  <= drop_last;
		end else if (emit_pop) begin
			out_val_q  <= best_val;
			out_lane_q <= best_lane;
			out_st_q   <= ST_MERGED;
			out_done_q <= done_now;
			out_end_q  <= pop_last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.merged_value = out_val_q;
	assign out_ch.source_lane  = out_lane_q;
	assign out_ch.status       = out_st_q;
	assign out_ch.merge_done   = out_done_q;
	assign out_ch.burst_end    = out_end_q;

endmodule
`default_nettype wire

/* hw/rtl/k_way_sorted_stream_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_sorted_stream_merge
// Merges up to LANES ascending signed streams into one ascending stream.
// ----------------------------------------------------------------------------
// Each transfer on in_ch pushes one value into its lane's buffer (or is dropped
// with a status result). Pushes wait in a two-entry queue; the merge engine
// takes one push only when idle and takes no other until it has applied it
// and emitted the results it causes (zero to 16). Results leave through an
// output register and stall on out_ch.ready. A merged result is emitted only
// while every open, active lane holds a value; ties go to the lowest lane.
// active_lanes (cfg_wdata) may be written only while the block is idle.
// ----------------------------------------------------------------------------
module k_way_sorted_stream_merge import kwm_pkg::*; #(
	parameter int LANES       = 4,
	parameter int LANE_DEPTH  = 4,
	parameter int VALUE_WIDTH = 32
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire [LANES-1:0] cfg_wdata,
	kwm_in_if.sink          in_ch,
	kwm_out_if.source       out_ch
);
	localparam int LANE_W = $clog2(LANES);

	logic [LANES-1:0]              active_q;
	logic                          q_valid;
	logic [LANE_W-1:0]             q_lane;
	logic signed [VALUE_WIDTH-1:0] q_value;
	kwm_cls_t                      q_cls;
	logic                          take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= LANES'(4'hF);
		else if (cfg_we)
			active_q <= cfg_wdata;
	end

	kwm_front #(
		.LANES       (LANES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_lane  (q_lane),
		.q_value (q_value),
		.q_cls   (q_cls),
		.take    (take)
	);

	kwm_back #(
		.LANES       (LANES),
		.LANE_DEPTH  (LANE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.active  (active_q),
		.q_valid (q_valid),
		.q_lane  (q_lane),
		.q_value (q_value),
		.q_cls   (q_cls),
		.take    (take),
		.out_ch  (out_ch)
	);

	a_done_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.merge_done |-> out_ch.status == ST_MERGED && out_ch.burst_end)
		else $error("merge_done on a drop or mid-burst result");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status != ST_MERGED |-> out_ch.merged_value == '0)
		else $error("drop result carries a value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.status == ST_MERGED || out_ch.status == ST_FULL ||
			out_ch.status == ST_CLOSED)
		else $error("undefined status code");

endmodule
`default_nettype wire
